@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/pfa_pkg.sv @@
// Package: constants, request and status codes for the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;
  localparam int MaxPages = 4096;
  localparam int PW = $clog2(MaxPages);
  localparam int CW = PW + 1;
  localparam logic [7:0] RefLimit = 8'd255;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_RESERVE = 3'd2;
  localparam logic [2:0] REQ_RETAIN  = 3'd3;
  localparam logic [2:0] REQ_REFQ    = 3'd4;
  localparam logic [2:0] REQ_USEDQ   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  // One entry of the page store: used bit and owner count.
  typedef struct packed {
    logic       used;
    logic [7:0] cnt;
  } page_ent_t;
endpackage

@@ hw/rtl/pfa_page_ram.sv @@
// Page store: one read port, one write port, registered read data.
`timescale 1ns / 1ps
module pfa_page_ram
  import pfa_pkg::*;
(
  input  logic          clk,
  input  logic          rd_en,
  input  logic [PW-1:0] rd_addr,
  output page_ent_t     rd_data,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  page_ent_t     wr_data
);
  page_ent_t mem [MaxPages];

  // Write and read in one clocked block.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

@@ hw/rtl/page_frame_allocator_refcount.sv @@
// Top level: page frame allocator with per-page reference counts.
`timescale 1ns / 1ps
// Usage: pulse start with a request while busy is low; the request is
// taken at that edge and busy rises. One result comes back on out_valid for
// a single cycle with status, base page, run-in-use flag, ref count and the
// used page total. The receiver cannot stall; results are never held.
// Sequencing: all page state lives in one RAM with registered read data, so
// each page touched is read in S_RD and evaluated in S_EV before the next
// page. A request rejected up front goes straight to S_DONE; retain and
// refcount query touch one page; free, reserve and used query touch every
// page of the run. Alloc scans from the hint, restarting its candidate past
// any used page, then marks the run. The next item can be taken at the edge
// that takes the result.
// Reset: after rst_n falls low and rises, a clearing pass walks the RAM one
// entry per cycle with busy high. Configuration writes on the APB port
// (total_pages at address 0) are taken at any time, pready is always
// high; write only when idle.
module page_frame_allocator_refcount
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [11:0] in_page_index,
  input  logic [12:0] in_page_count,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_base_page,
  output logic        out_run_in_use,
  output logic [7:0]  out_ref_count,
  output logic [12:0] out_used_pages,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EV    = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_HEADV = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  logic [3:0]    st_r, st_nxt;
  logic [12:0]   total_r;
  logic [CW-1:0] hint_r, hint_nxt, used_r, used_nxt;
  logic [2:0]    typ_r;
  logic [CW-1:0] base_r, base_nxt, cnt_r, cnt_nxt, pos_r, pos_nxt, lim_r;
  logic          pass_r, pass_nxt, busy_hit_r, busy_hit_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [7:0]    refc_r, refc_nxt;
  logic          ov_r;
  logic [1:0]    ostat_r;
  logic [11:0]   obase_r;
  logic          obusy_r;
  logic [7:0]    orefc_r;
  logic [CW-1:0] clr_r;

  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  page_ent_t     rd_data, wr_data;

  pfa_page_ram u_ram (
    .clk, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  logic          cfg_wr;
  logic [CW-1:0] tot;
  logic [CW-1:0] idx_w, n_w;
  logic [CW:0]   end_w;
  logic          accept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? {19'd0, total_r} : 32'd0;
  assign tot    = (total_r > 13'(MaxPages)) ? CW'(MaxPages) : CW'(total_r);
  assign busy   = (st_r != S_IDLE);
  assign accept = start && !busy;
  assign idx_w  = CW'(in_page_index);
  assign n_w    = CW'(in_page_count);
  assign end_w  = {1'b0, idx_w} + {1'b0, n_w};

  // Sequencer: read entry at pos, evaluate, optionally write back.
  always_comb begin
    st_nxt = st_r; hint_nxt = hint_r; used_nxt = used_r;
    base_nxt = base_r; cnt_nxt = cnt_r; pos_nxt = pos_r;
    pass_nxt = pass_r; busy_hit_nxt = busy_hit_r;
    stat_nxt = stat_r; refc_nxt = refc_r;
    rd_en = 1'b0; rd_addr = pos_r[PW-1:0];
    wr_en = 1'b0; wr_addr = pos_r[PW-1:0]; wr_data = '0;
    unique case (st_r)
      S_CLR: begin
        wr_en = 1'b1; wr_addr = clr_r[PW-1:0];
        if (clr_r == CW'(MaxPages - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          stat_nxt = ST_OK; refc_nxt = '0; busy_hit_nxt = 1'b0;
          base_nxt = idx_w; pos_nxt = idx_w; cnt_nxt = n_w; pass_nxt = 1'b0;
          st_nxt = S_RD;
          priority case (in_req_type)
            REQ_ALLOC: begin
              if (n_w == '0) begin stat_nxt = ST_RANGE; st_nxt = S_DONE; end
              else if (n_w > tot || {1'b0, hint_r} + {1'b0, n_w} > {1'b0, tot})
              begin
                stat_nxt = ST_OOM; st_nxt = S_DONE;
              end else begin
                base_nxt = hint_r; pos_nxt = hint_r; cnt_nxt = '0;
              end
            end
            REQ_FREE, REQ_RESERVE, REQ_USEDQ: begin
              if (n_w == '0 || end_w > {1'b0, tot}) begin
                stat_nxt = ST_RANGE; st_nxt = S_DONE;
              end
            end
            REQ_RETAIN, REQ_REFQ: begin
              if (idx_w >= tot) begin stat_nxt = ST_RANGE; st_nxt = S_DONE; end
            end
            default: begin stat_nxt = ST_RANGE; st_nxt = S_DONE; end
          endcase
        end
      end
      S_RD: begin
        rd_en = 1'b1; st_nxt = S_EV;
      end
      S_EV: begin
        st_nxt = S_RD; pos_nxt = pos_r + 1'b1;
        priority case (typ_r)
          REQ_ALLOC: begin
            if (!pass_r) begin
              // Search: count free pages from candidate base.
              if (rd_data.used) begin
                base_nxt = pos_r + 1'b1; cnt_nxt = '0;
                if ({1'b0, pos_r} + 2'd1 + {1'b0, lim_r} > {1'b0, tot}) begin
                  stat_nxt = ST_OOM; st_nxt = S_DONE;
                end
              end else if (cnt_r + 1'b1 == lim_r) begin
                pass_nxt = 1'b1; pos_nxt = base_r; cnt_nxt = '0;
              end else cnt_nxt = cnt_r + 1'b1;
            end else begin
              // Mark: every page of the run is free.
              wr_en = 1'b1; wr_data.used = 1'b1; wr_data.cnt = 8'd1;
              used_nxt = used_r + 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r + 1'b1 == lim_r) begin
                if (hint_r >= base_r && hint_r <= pos_r) hint_nxt = pos_r + 1'b1;
                refc_nxt = 8'd1; st_nxt = S_DONE;
              end
            end
          end
          REQ_RESERVE: begin
            if (!rd_data.used) begin
              wr_en = 1'b1; wr_data.used = 1'b1; wr_data.cnt = 8'd1;
              used_nxt = used_r + 1'b1;
              if (pos_r == hint_nxt) hint_nxt = pos_r + 1'b1;
            end
            if (pos_r == base_r) refc_nxt = rd_data.used ? rd_data.cnt : 8'd1;
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == CW'(1)) st_nxt = S_DONE;
          end
          REQ_FREE: begin
            if (rd_data.used) begin
              wr_en = 1'b1;
              if (rd_data.cnt > 8'd1) begin
                wr_data.used = 1'b1; wr_data.cnt = rd_data.cnt - 8'd1;
              end else begin
                used_nxt = used_r - 1'b1;
                if (pos_r < hint_nxt) hint_nxt = pos_r;
              end
            end
            if (pos_r == base_r)
              refc_nxt = (rd_data.used && rd_data.cnt != 8'd0) ?
                         rd_data.cnt - 8'd1 : rd_data.cnt;
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == CW'(1)) st_nxt = S_DONE;
          end
          REQ_USEDQ: begin
            if (rd_data.used) busy_hit_nxt = 1'b1;
            if (pos_r == base_r) refc_nxt = rd_data.cnt;
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == CW'(1)) st_nxt = S_DONE;
          end
          REQ_RETAIN: begin
            wr_en = 1'b1; wr_data = rd_data;
            if (rd_data.cnt == RefLimit) begin
              stat_nxt = ST_OVF; refc_nxt = RefLimit;
            end else begin
              wr_data.cnt = (rd_data.cnt == 8'd0) ? 8'd2 : rd_data.cnt + 8'd1;
              refc_nxt = wr_data.cnt;
            end
            st_nxt = S_DONE;
          end
          default: begin
            refc_nxt = rd_data.cnt; st_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; hint_r <= '0; used_r <= '0;
      total_r <= 13'(MaxPages); ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; hint_r <= hint_nxt; used_r <= used_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_wr) total_r <= pwdata[12:0];
      ov_r <= (st_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt; pass_r <= pass_nxt;
    busy_hit_r <= busy_hit_nxt; stat_r <= stat_nxt; refc_r <= refc_nxt;
    if (accept) begin typ_r <= in_req_type; lim_r <= n_w; end
    if (st_r == S_DONE) begin
      ostat_r <= stat_r;
      obase_r <= (typ_r == REQ_ALLOC && stat_r == ST_OK) ? base_r[PW-1:0] : '0;
      obusy_r <= (typ_r == REQ_USEDQ && stat_r == ST_OK) ? busy_hit_r : 1'b0;
      orefc_r <= (stat_r == ST_OK || stat_r == ST_OVF) ? refc_r : 8'd0;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_base_page  = obase_r;
  assign out_run_in_use = obusy_r;
  assign out_ref_count  = orefc_r;
  assign out_used_pages = used_r;
endmodule

@@ hw/rtl/pfa_checker.sv @@
// Port-level checker for the page frame allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfa_checker
  import pfa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [11:0] out_base_page,
  input logic        out_run_in_use,
  input logic [12:0] out_used_pages
);
  `AST_NEXT(a_acc_busy, clk, rst_n, start && !busy, busy, "busy must rise on accept")
  `AST_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `AST_IMPL(a_res_idle, clk, rst_n, out_valid, !busy, "result while still busy")
  `AST_IMPL(a_base_ok, clk, rst_n, out_valid && out_status != ST_OK, out_base_page == '0 && !out_run_in_use, "fields set on failure")
  `AST_IMPL(a_used_max, clk, rst_n, 1'b1, out_used_pages <= 13'(MaxPages), "used count above page total")
endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_base_page,
  .out_run_in_use, .out_used_pages
);
